>>> hw/rtl/hss_pkg.sv
// Shared types, register indexes and fixed-point helpers for the 3D heat stencil step.
// Used by hss_ctrl, hss_datapath and heat_stencil_3d_step.
`default_nettype none

package hss_pkg;

   localparam int DataW = 32;
   localparam int SumW  = 56;
   localparam int SizeW = 9;
   localparam int EffW  = 11;   // effective extent, holds up to 2047

   // register indexes on the csr port
   localparam logic [2:0] CSR_SIZE_X       = 3'd0;
   localparam logic [2:0] CSR_SIZE_Y       = 3'd1;
   localparam logic [2:0] CSR_SIZE_Z       = 3'd2;
   localparam logic [2:0] CSR_CONDUCTANCE  = 3'd3;
   localparam logic [2:0] CSR_RADIATION    = 3'd4;
   localparam logic [2:0] CSR_HEATER_POWER = 3'd5;
   localparam logic [2:0] CSR_TIME_STEP    = 3'd6;

   localparam logic MODE_CELL  = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   // neighbor presence bits
   localparam int NB_XM = 0;
   localparam int NB_XP = 1;
   localparam int NB_YM = 2;
   localparam int NB_YP = 3;
   localparam int NB_ZM = 4;
   localparam int NB_ZP = 5;

   typedef struct packed {
      logic signed [DataW-1:0] conductance;
      logic signed [DataW-1:0] radiation;
      logic signed [DataW-1:0] heater_power;
      logic signed [DataW-1:0] time_step;
   } coef_type;

   typedef struct packed {
      logic                    valid;
      logic                    use_in;   // x+1 neighbor is the arriving word
      logic signed [DataW-1:0] t_in;
      logic [5:0]              nbr;
      logic                    last;
      logic signed [SumW-1:0]  sum;
   } emit_type;

   function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
      logic signed [31:0] r;
      if (v > 38'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -38'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Q16.16 product, floor shift, saturate
   function automatic logic signed [31:0] qmul(input logic signed [32:0] a,
                                               input logic signed [31:0] b);
      logic signed [64:0] p;
      logic signed [48:0] s;
      logic signed [31:0] r;
      p = a * b;
      s = p[64:16];
      if (s > 49'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (s < -49'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/heat_stencil_3d_step.sv
// Top level of the streamed 3D heat stencil step: registers, window banks, control, pipeline.
// Depends on hss_pkg, hss_ram, hss_ctrl and hss_datapath.
`default_nettype none

// channel   direction  words
// req_      in         mode, temperature (raster order, z fastest; mode 1 drains)
// rsp_      out        new_temperature, rate, grid_sum, last_cell
// csr_      in         write enable, index, 32-bit data; no read-back
//
// One word per cycle in, one per cycle out while rsp_ is not stalled; a result leaves
// after the word completing its neighborhood (cell n + size_y*size_z, or a drain word).
// The window is three copies of a two-plane store, each with two read ports,
// so all six neighbor reads and the write of the arriving cell happen in the same cycle.
// Synchronous reset; req_ready is held low after reset and after each register write
// until warm_ff has filled, while the grid extents settle.
// A stalled rsp_ side freezes the whole pipeline.

module heat_stencil_3d_step #(
   parameter int MAX_X = 256,
   parameter int MAX_Y = 256,
   parameter int MAX_Z = 256
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_mode,
   input  wire logic signed [hss_pkg::DataW-1:0] req_temperature,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [hss_pkg::DataW-1:0]      rsp_new_temperature,
   output logic signed [hss_pkg::DataW-1:0]      rsp_rate,
   output logic signed [hss_pkg::SumW-1:0]       rsp_grid_sum,
   output logic                                  rsp_last_cell,
   input  wire logic                             csr_write_enable,
   input  wire logic [2:0]                       csr_index,
   input  wire logic [hss_pkg::DataW-1:0]        csr_write_data
);

   localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
   localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
   localparam int AW = 1 + YW + ZW;
   localparam int PW = $clog2(MAX_X*MAX_Y*MAX_Z+1);
   localparam int EW = hss_pkg::EffW;

   logic [hss_pkg::SizeW-1:0] size_x_ff, size_y_ff, size_z_ff;
   hss_pkg::coef_type         coef_ff;
   logic [PW-1:0]             plane_ff, plane_in, total_ff, total_in;
   logic [1:0]                warm_ff;

   logic [EW-1:0]             nx, ny, nz;
   logic                      en, accept;
   logic                      wr_en, rd_en;
   logic [AW-1:0]             wr_addr;
   logic [AW-1:0]             rd_addr [6];
   logic [hss_pkg::DataW-1:0] rd_data [6];
   hss_pkg::emit_type         emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff            <= hss_pkg::SizeW'(200);
         size_y_ff            <= hss_pkg::SizeW'(200);
         size_z_ff            <= hss_pkg::SizeW'(200);
         coef_ff.conductance  <= 32'sd65536;
         coef_ff.radiation    <= 32'sd65536;
         coef_ff.heater_power <= 32'sd65536;
         coef_ff.time_step    <= 32'sd6554;
      end else if (csr_write_enable) begin
         case (csr_index)
            hss_pkg::CSR_SIZE_X: begin
               size_x_ff <= csr_write_data[hss_pkg::SizeW-1:0];
            end
            hss_pkg::CSR_SIZE_Y: begin
               size_y_ff <= csr_write_data[hss_pkg::SizeW-1:0];
            end
            hss_pkg::CSR_SIZE_Z: begin
               size_z_ff <= csr_write_data[hss_pkg::SizeW-1:0];
            end
            hss_pkg::CSR_CONDUCTANCE: begin
               coef_ff.conductance <= csr_write_data;
            end
            hss_pkg::CSR_RADIATION: begin
               coef_ff.radiation <= csr_write_data;
            end
            hss_pkg::CSR_HEATER_POWER: begin
               coef_ff.heater_power <= csr_write_data;
            end
            hss_pkg::CSR_TIME_STEP: begin
               coef_ff.time_step <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   // zero counts as one, anything past the window limit clamps to it
   always_comb begin
      nx = (size_x_ff == '0) ? EW'(1) :
           (EW'(size_x_ff) > EW'(MAX_X)) ? EW'(MAX_X) : EW'(size_x_ff);
      ny = (size_y_ff == '0) ? EW'(1) :
           (EW'(size_y_ff) > EW'(MAX_Y)) ? EW'(MAX_Y) : EW'(size_y_ff);
      nz = (size_z_ff == '0) ? EW'(1) :
           (EW'(size_z_ff) > EW'(MAX_Z)) ? EW'(MAX_Z) : EW'(size_z_ff);
      plane_in = PW'(ny) * PW'(nz);
      total_in = PW'(nx) * plane_ff;
   end

   always_ff @(posedge clock) begin
      plane_ff <= plane_in;
      total_ff <= total_in;
   end

   // plane and total follow a register write through plane_ff and then total_ff
   always_ff @(posedge clock) begin
      if (reset || csr_write_enable) begin
         warm_ff <= 2'b00;
      end else begin
         warm_ff <= {warm_ff[0], 1'b1};
      end
   end

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en && warm_ff[1];
   assign accept    = req_valid && req_ready;

   hss_ctrl #(
      .MAX_X (MAX_X),
      .MAX_Y (MAX_Y),
      .MAX_Z (MAX_Z)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .mode        (req_mode),
      .temperature (req_temperature),
      .nx          (nx),
      .ny          (ny),
      .nz          (nz),
      .plane       (plane_ff),
      .total       (total_ff),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .emit        (emit)
   );

   for (genvar b = 0; b < 3; b++) begin : g_bank
      hss_ram #(
         .AW (AW),
         .DW (hss_pkg::DataW)
      ) u_ram (
         .clock     (clock),
         .wr_en     (wr_en),
         .wr_addr   (wr_addr),
         .wr_data   (req_temperature),
         .rd_en     (rd_en),
         .rd_addr_a (rd_addr[2*b]),
         .rd_addr_b (rd_addr[2*b+1]),
         .rd_data_a (rd_data[2*b]),
         .rd_data_b (rd_data[2*b+1])
      );
   end

   hss_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .en                  (en),
      .coef                (coef_ff),
      .emit                (emit),
      .rd_data             (rd_data),
      .out_valid           (rsp_valid),
      .out_new_temperature (rsp_new_temperature),
      .out_rate            (rsp_rate),
      .out_grid_sum        (rsp_grid_sum),
      .out_last_cell       (rsp_last_cell)
   );

endmodule

`default_nettype wire

>>> hw/rtl/hss_ram.sv
// Plane window bank: one write port, two registered read ports.
// No package dependency.
`default_nettype none

module hss_ram #(
   parameter int AW = 17,
   parameter int DW = 32
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr_a,
   input  wire logic [AW-1:0] rd_addr_b,
   output logic      [DW-1:0] rd_data_a,
   output logic      [DW-1:0] rd_data_b
);

   logic [DW-1:0] mem [2**AW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read-first: a read and a write of one entry in a cycle returns the old word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/hss_ctrl.sv
// Stream position tracking, window addressing and old temperature sum.
// Depends on hss_pkg.
`default_nettype none

module hss_ctrl #(
   parameter int MAX_X = 256,
   parameter int MAX_Y = 256,
   parameter int MAX_Z = 256
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             accept,
   input  wire logic                             mode,
   input  wire logic signed [hss_pkg::DataW-1:0] temperature,
   input  wire logic [hss_pkg::EffW-1:0]         nx,
   input  wire logic [hss_pkg::EffW-1:0]         ny,
   input  wire logic [hss_pkg::EffW-1:0]         nz,
   input  wire logic [$clog2(MAX_X*MAX_Y*MAX_Z+1)-1:0] plane,
   input  wire logic [$clog2(MAX_X*MAX_Y*MAX_Z+1)-1:0] total,
   output logic                                  wr_en,
   output logic [((MAX_Y>1)?$clog2(MAX_Y):1)+((MAX_Z>1)?$clog2(MAX_Z):1):0] wr_addr,
   output logic                                  rd_en,
   output logic [((MAX_Y>1)?$clog2(MAX_Y):1)+((MAX_Z>1)?$clog2(MAX_Z):1):0] rd_addr [6],
   output hss_pkg::emit_type                     emit
);

   localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
   localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
   localparam int PW = $clog2(MAX_X*MAX_Y*MAX_Z+1);
   localparam int CW = hss_pkg::EffW + 1;
   localparam int SW = hss_pkg::SumW;

   logic [PW-1:0]        in_pos_ff, in_pos_in, out_pos_ff, out_pos_in;
   logic                 ix0_ff, ix0_in;
   logic [YW-1:0]        iy_ff, iy_in, oy_ff, oy_in;
   logic [ZW-1:0]        iz_ff, iz_in, oz_ff, oz_in;
   logic [XW-1:0]        ox_ff, ox_in;
   logic signed [SW-1:0] sum_ff, sum_in;

   logic                 frame_bad, take_cell, cell_emit, drain_emit, do_emit, is_last;
   logic [PW-1:0]        in_pos, out_pos;
   logic                 ix0;
   logic [YW-1:0]        iy, oy;
   logic [ZW-1:0]        iz, oz;
   logic [XW-1:0]        ox;
   logic signed [SW-1:0] sum;
   logic [PW:0]          out_plus;
   logic                 iz_wrap, iy_wrap, oz_wrap, oy_wrap;
   logic signed [SW:0]   sum_wide;
   logic [5:0]           nbr;

   always_comb begin
      frame_bad = (in_pos_ff > total) || (out_pos_ff >= total) || (out_pos_ff > in_pos_ff);
      in_pos  = frame_bad ? '0 : in_pos_ff;
      out_pos = frame_bad ? '0 : out_pos_ff;
      ix0     = frame_bad ? 1'b0 : ix0_ff;
      iy      = frame_bad ? '0 : iy_ff;
      iz      = frame_bad ? '0 : iz_ff;
      ox      = frame_bad ? '0 : ox_ff;
      oy      = frame_bad ? '0 : oy_ff;
      oz      = frame_bad ? '0 : oz_ff;
      sum     = frame_bad ? '0 : sum_ff;

      out_plus   = {1'b0, out_pos} + {1'b0, plane};
      take_cell  = (mode == hss_pkg::MODE_CELL) && (in_pos < total);
      cell_emit  = take_cell && ({1'b0, in_pos} >= out_plus);
      drain_emit = !take_cell && (in_pos >= total) && (out_pos < total);
      do_emit    = cell_emit || drain_emit;
      is_last    = do_emit && (({1'b0, out_pos} + (PW+1)'(1)) == {1'b0, total});

      nbr            = '0;
      nbr[hss_pkg::NB_XM] = (ox != '0);
      nbr[hss_pkg::NB_XP] = ((CW'(ox) + CW'(1)) < CW'(nx));
      nbr[hss_pkg::NB_YM] = (oy != '0);
      nbr[hss_pkg::NB_YP] = ((CW'(oy) + CW'(1)) < CW'(ny));
      nbr[hss_pkg::NB_ZM] = (oz != '0);
      nbr[hss_pkg::NB_ZP] = ((CW'(oz) + CW'(1)) < CW'(nz));

      iz_wrap = (CW'(iz) + CW'(1)) >= CW'(nz);
      iy_wrap = (CW'(iy) + CW'(1)) >= CW'(ny);
      oz_wrap = (CW'(oz) + CW'(1)) >= CW'(nz);
      oy_wrap = (CW'(oy) + CW'(1)) >= CW'(ny);

      sum_wide = {sum[SW-1], sum} + (SW+1)'(temperature);
   end

   // window address is {x parity, y, z}
   always_comb begin
      wr_en      = accept && take_cell;
      wr_addr    = {ix0, iy, iz};
      rd_en      = accept && do_emit;
      rd_addr[0] = {ox[0], oy, oz};
      rd_addr[1] = {~ox[0], oy, oz};   // x-1 and x+1 share this word
      rd_addr[2] = {ox[0], oy - YW'(1), oz};
      rd_addr[3] = {ox[0], oy + YW'(1), oz};
      rd_addr[4] = {ox[0], oy, oz - ZW'(1)};
      rd_addr[5] = {ox[0], oy, oz + ZW'(1)};

      emit.valid  = accept && do_emit;
      emit.use_in = cell_emit && ({1'b0, in_pos} == out_plus);
      emit.t_in   = temperature;
      emit.nbr    = nbr;
      emit.last   = is_last;
      emit.sum    = is_last ? sum : '0;
   end

   always_comb begin
      in_pos_in  = in_pos;
      out_pos_in = out_pos;
      ix0_in     = ix0;
      iy_in      = iy;
      iz_in      = iz;
      ox_in      = ox;
      oy_in      = oy;
      oz_in      = oz;
      sum_in     = sum;
      if (take_cell) begin
         in_pos_in = in_pos + PW'(1);
         if (iz_wrap) begin
            iz_in = '0;
            if (iy_wrap) begin
               iy_in  = '0;
               ix0_in = ~ix0;
            end else begin
               iy_in = iy + YW'(1);
            end
         end else begin
            iz_in = iz + ZW'(1);
         end
         if (sum_wide > $signed({2'b00, {(SW-1){1'b1}}})) begin
            sum_in = {1'b0, {(SW-1){1'b1}}};
         end else if (sum_wide < $signed({1'b1, 1'b1, {(SW-1){1'b0}}})) begin
            sum_in = {1'b1, {(SW-1){1'b0}}};
         end else begin
            sum_in = sum_wide[SW-1:0];
         end
      end
      if (do_emit) begin
         out_pos_in = out_pos + PW'(1);
         if (oz_wrap) begin
            oz_in = '0;
            if (oy_wrap) begin
               oy_in = '0;
               ox_in = ox + XW'(1);
            end else begin
               oy_in = oy + YW'(1);
            end
         end else begin
            oz_in = oz + ZW'(1);
         end
      end
      if (is_last) begin
         in_pos_in  = '0;
         out_pos_in = '0;
         ix0_in     = 1'b0;
         iy_in      = '0;
         iz_in      = '0;
         ox_in      = '0;
         oy_in      = '0;
         oz_in      = '0;
         sum_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_pos_ff  <= '0;
         out_pos_ff <= '0;
         ix0_ff     <= 1'b0;
         iy_ff      <= '0;
         iz_ff      <= '0;
         ox_ff      <= '0;
         oy_ff      <= '0;
         oz_ff      <= '0;
         sum_ff     <= '0;
      end else if (accept) begin
         in_pos_ff  <= in_pos_in;
         out_pos_ff <= out_pos_in;
         ix0_ff     <= ix0_in;
         iy_ff      <= iy_in;
         iz_ff      <= iz_in;
         ox_ff      <= ox_in;
         oy_ff      <= oy_in;
         oz_ff      <= oz_in;
         sum_ff     <= sum_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/hss_datapath.sv
// Arithmetic pipeline: conduction terms, radiation chain, rate and new temperature.
// Depends on hss_pkg.
`default_nettype none

module hss_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             en,
   input  wire hss_pkg::coef_type                coef,
   input  wire hss_pkg::emit_type                emit,
   input  wire logic [hss_pkg::DataW-1:0]        rd_data [6],
   output logic                                  out_valid,
   output logic signed [hss_pkg::DataW-1:0]      out_new_temperature,
   output logic signed [hss_pkg::DataW-1:0]      out_rate,
   output logic signed [hss_pkg::SumW-1:0]       out_grid_sum,
   output logic                                  out_last_cell
);

   typedef struct packed {
      logic signed [hss_pkg::DataW-1:0] t;
      logic                             last;
      logic signed [hss_pkg::SumW-1:0]  sum;
   } carry_type;

   // stage 1: window words arrive
   hss_pkg::emit_type e1_ff;
   // stage 2: conduction products, first radiation product
   logic                    v2_ff;
   logic signed [31:0]      c2_ff [6];
   logic [5:0]              nbr2_ff;
   logic signed [31:0]      r2_ff;
   carry_type               k2_ff;
   // stages 3..5: radiation chain
   logic                    v3_ff, v4_ff, v5_ff;
   logic signed [34:0]      cs3_ff, cs4_ff, cs5_ff;
   logic [2:0]              f3_ff, f4_ff, f5_ff;
   logic signed [31:0]      r3_ff, r4_ff, r5_ff;
   carry_type               k3_ff, k4_ff, k5_ff;
   // stage 6: rate; stage 7: dt product
   logic                    v6_ff, v7_ff;
   logic signed [31:0]      rate6_ff, rate7_ff, p7_ff;
   carry_type               k6_ff, k7_ff;
   // result word
   logic                    vo_ff;
   logic signed [31:0]      nt_ff, rate_ff;
   logic signed [55:0]      gsum_ff;
   logic                    last_ff;

   logic signed [31:0] t1, xp1;
   logic signed [31:0] nb1 [6];
   logic signed [31:0] c1 [6];
   logic signed [34:0] cs2;
   logic [2:0]         f2;
   logic signed [35:0] rad5;
   logic signed [37:0] acc5;
   logic signed [37:0] nt7;

   always_comb begin
      t1  = rd_data[0];
      xp1 = e1_ff.use_in ? e1_ff.t_in : rd_data[1];
      nb1[hss_pkg::NB_XM] = rd_data[1];
      nb1[hss_pkg::NB_XP] = xp1;
      nb1[hss_pkg::NB_YM] = rd_data[2];
      nb1[hss_pkg::NB_YP] = rd_data[3];
      nb1[hss_pkg::NB_ZM] = rd_data[4];
      nb1[hss_pkg::NB_ZP] = rd_data[5];
      for (int i = 0; i < 6; i++) begin
         c1[i] = hss_pkg::qmul(33'(nb1[i]) - 33'(t1), coef.conductance);
      end
   end

   always_comb begin
      cs2 = nbr2_ff[hss_pkg::NB_XM] ? 35'sd0 : 35'(coef.heater_power);
      for (int i = 0; i < 6; i++) begin
         if (nbr2_ff[i]) begin
            cs2 = cs2 + 35'(c2_ff[i]);
         end
      end
      f2   = 3'd6 - 3'($countones(nbr2_ff));
      rad5 = r5_ff * $signed({1'b0, f5_ff});
      acc5 = 38'(cs5_ff) - 38'(rad5);
      nt7  = 38'(k7_ff.t) + 38'(p7_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_ff.valid <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         e1_ff <= emit;
         v2_ff <= e1_ff.valid;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         vo_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c2_ff      <= c1;
         nbr2_ff    <= e1_ff.nbr;
         r2_ff      <= hss_pkg::qmul(33'(coef.radiation), t1);
         k2_ff.t    <= t1;
         k2_ff.last <= e1_ff.last;
         k2_ff.sum  <= e1_ff.sum;

         cs3_ff <= cs2;
         f3_ff  <= f2;
         r3_ff  <= hss_pkg::qmul(33'(r2_ff), k2_ff.t);
         k3_ff  <= k2_ff;

         cs4_ff <= cs3_ff;
         f4_ff  <= f3_ff;
         r4_ff  <= hss_pkg::qmul(33'(r3_ff), k3_ff.t);
         k4_ff  <= k3_ff;

         cs5_ff <= cs4_ff;
         f5_ff  <= f4_ff;
         r5_ff  <= hss_pkg::qmul(33'(r4_ff), k4_ff.t);
         k5_ff  <= k4_ff;

         rate6_ff <= hss_pkg::sat32(acc5);
         k6_ff    <= k5_ff;

         p7_ff    <= hss_pkg::qmul(33'(coef.time_step), rate6_ff);
         rate7_ff <= rate6_ff;
         k7_ff    <= k6_ff;

         nt_ff   <= hss_pkg::sat32(nt7);
         rate_ff <= rate7_ff;
         gsum_ff <= k7_ff.sum;
         last_ff <= k7_ff.last;
      end
   end

   assign out_valid           = vo_ff;
   assign out_new_temperature = nt_ff;
   assign out_rate            = rate_ff;
   assign out_grid_sum        = gsum_ff;
   assign out_last_cell       = last_ff;

endmodule

`default_nettype wire
